// File: rtl/mtne_pkg.sv
// Shared types, constants and lookup tables of the MIDI track note extractor.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package mtne_pkg;

  localparam int CHANNELS          = 16;
  localparam int NOTES_PER_CHANNEL = 128;
  localparam int TIME_FRAC         = 8;

  localparam int KEY_W      = 7;
  localparam int SLOT_COUNT = CHANNELS * NOTES_PER_CHANNEL;
  localparam int SLOT_AW    = $clog2(SLOT_COUNT);
  localparam int CURSOR_W   = 11;
  localparam int FX_W       = 48;
  localparam int US_W       = 40;
  localparam int PROD_W     = 56;
  localparam int DIV_W      = PROD_W + TIME_FRAC;
  localparam int DCNT_W     = $clog2(DIV_W);

  localparam logic [FX_W-1:0] MAX48      = '1;
  localparam logic [FX_W-1:0] MAX40_FX   = FX_W'(64'hFF_FFFF_FFFF);
  localparam logic [FX_W-1:0] MIN_DUR_FX = FX_W'(64'd10000 << TIME_FRAC);
  localparam logic [23:0]     TEMPO_RESET = 24'd500000;
  localparam logic [14:0]     TPQ_RESET   = 15'd96;

  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [3:0] TY_NOTE_OFF  = 4'h8;
  localparam logic [3:0] TY_NOTE_ON   = 4'h9;
  localparam logic [3:0] TY_PROGRAM   = 4'hC;
  localparam logic [3:0] TY_PRESSURE  = 4'hD;
  localparam logic       KIND_NOTE    = 1'b0;
  localparam logic       KIND_DONE    = 1'b1;

  typedef struct packed {
    logic            active;
    logic [FX_W-1:0] start_fx;
    logic [3:0]      voice;
  } slot_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_AW-1:0] addr;
    slot_t              data;
  } slot_wr_t;

  typedef struct packed {
    logic        start;
    logic [31:0] ticks;
    logic [23:0] tempo;
    logic [14:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [FX_W-1:0] delta_fx;
  } div_rsp_t;

  typedef logic [21:0]        freq_tab_t [NOTES_PER_CHANNEL];
  typedef logic signed [15:0] pan_tab_t [16];

  localparam logic [3:0] VOICE_TAB [36] = '{
    0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 2, 2, 2, 2, 3, 3, 3, 3,
    4, 4, 4, 4, 5, 5, 5, 6, 7, 7, 7, 8, 9, 8, 10, 10
  };

  function automatic logic [63:0] base_nano(input int m);
    logic [63:0] v;
    unique case (m)
      0:       v = 64'd2093004522405;
      1:       v = 64'd2217461047815;
      2:       v = 64'd2349318143339;
      3:       v = 64'd2489015869777;
      4:       v = 64'd2637020455303;
      5:       v = 64'd2793825851464;
      6:       v = 64'd2959955381693;
      7:       v = 64'd3135963487854;
      8:       v = 64'd3322437580640;
      9:       v = 64'd3520000000000;
      10:      v = 64'd3729310092145;
      default: v = 64'd3951066410049;
    endcase
    return v;
  endfunction

  function automatic freq_tab_t build_freq_tab();
    freq_tab_t   t;
    logic [63:0] v;
    for (int k = 0; k < NOTES_PER_CHANNEL; k++) begin
      v    = base_nano(k % 12) << (k / 12);
      t[k] = 22'((v + 64'd500000000) / 64'd1000000000);
    end
    return t;
  endfunction

  function automatic pan_tab_t build_pan_tab();
    pan_tab_t t;
    int       n;
    int       p;
    for (int c = 0; c < 16; c++) begin
      n = (c * 2 - 15) * 16384;
      if (n >= 0) begin
        p = (n + 7) / 15;
      end else begin
        p = -((-n + 7) / 15);
      end
      t[c] = 16'(p);
    end
    return t;
  endfunction

  localparam freq_tab_t FREQ_TAB = build_freq_tab();
  localparam pan_tab_t  PAN_TAB  = build_pan_tab();

  function automatic logic [3:0] voice_of(input logic [7:0] prog);
    if (prog < 8'd36) begin
      return VOICE_TAB[prog[5:0]];
    end
    return 4'd0;
  endfunction

  function automatic logic [FX_W-1:0] sat_add48(input logic [FX_W-1:0] a,
                                               input logic [FX_W-1:0] b);
    logic [FX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[FX_W] ? MAX48 : s[FX_W-1:0];
  endfunction

  function automatic logic [US_W-1:0] fx_to_us(input logic [FX_W-1:0] fx);
    logic [FX_W-1:0] us;
    us = fx >> TIME_FRAC;
    return (us > MAX40_FX) ? MAX40_FX[US_W-1:0] : us[US_W-1:0];
  endfunction

endpackage

// File: rtl/mtne_divider.sv
// Delta-time converter: one multiply, then a restoring divide one bit a cycle.
// Depends on mtne_pkg for widths and the request and response structs.
`timescale 1ns / 1ps

module mtne_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  mtne_pkg::div_req_t req,
  output mtne_pkg::div_rsp_t rsp
);
  import mtne_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_MUL, D_RUN} dstate_t;

  dstate_t            state_r;
  logic [31:0]        ticks_r;
  logic [23:0]        tempo_r;
  logic [14:0]        div_r;
  logic [DIV_W-1:0]   dvd_r;
  logic [14:0]        rem_r;
  logic [DCNT_W-1:0]  cnt_r;
  logic               done_r;
  logic [15:0]        rem_sh;
  logic [15:0]        rem_sub;
  logic               ge;
  logic [PROD_W-1:0]  prod;

  assign rem_sh  = {rem_r, dvd_r[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, div_r};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign prod    = PROD_W'(ticks_r) * PROD_W'(tempo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
      ticks_r <= '0;
      tempo_r <= '0;
      div_r   <= '0;
      dvd_r   <= '0;
      rem_r   <= '0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (req.start) begin
            ticks_r <= req.ticks;
            tempo_r <= req.tempo;
            div_r   <= req.divisor;
            state_r <= D_MUL;
          end
        end
        D_MUL: begin
          dvd_r   <= DIV_W'(prod) << TIME_FRAC;
          rem_r   <= '0;
          cnt_r   <= DCNT_W'(DIV_W - 1);
          state_r <= D_RUN;
        end
        D_RUN: begin
          rem_r <= ge ? rem_sub[14:0] : rem_sh[14:0];
          dvd_r <= {dvd_r[DIV_W-2:0], ge};
          if (cnt_r == '0) begin
            done_r  <= 1'b1;
            state_r <= D_IDLE;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign rsp.done     = done_r;
  assign rsp.delta_fx = (|dvd_r[DIV_W-1:FX_W]) ? MAX48 : dvd_r[FX_W-1:0];

endmodule

// File: rtl/mtne_slot_store.sv
// Note slot memory, one entry per channel and key, with a registered read port.
// Holds the clearing pass after reset; depends on mtne_pkg for the slot types.
`timescale 1ns / 1ps

module mtne_slot_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clear_start,
  output logic                          busy,
  input  logic [mtne_pkg::SLOT_AW-1:0]  rd_addr,
  output mtne_pkg::slot_t               rd_data,
  input  mtne_pkg::slot_wr_t            wr
);
  import mtne_pkg::*;

  localparam logic [SLOT_AW-1:0] LAST = SLOT_AW'(SLOT_COUNT - 1);

  slot_t              mem [SLOT_COUNT];
  slot_t              rd_data_r;
  logic               busy_r;
  logic [SLOT_AW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (clear_start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == LAST) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[cnt_r] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign busy    = busy_r;
  assign rd_data = rd_data_r;

endmodule

// File: rtl/midi_track_note_extractor.sv
// Top level of the MIDI track note extractor: byte parser, slot sequencer, output register.
// Depends on mtne_pkg, mtne_divider and mtne_slot_store.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_command, in_track_byte
//   out_     output     out_valid/out_stall kind, times, key, pitch, voice, pan, status
//   cfg_     input      cfg_valid/cfg_ready cfg_data (ticks per quarter)
//
// Most bytes are taken in S_IDLE; a note event also goes through S_SLOT_RD and S_SLOT_MOD,
// then S_EMIT_A, S_EMIT_B and S_OUT when it finishes a note. A final delta-time byte waits
// in S_DIV for the bit-serial divider. A flush step scans the slot memory one entry a cycle.
// After reset and after an abandoned track, a clearing pass over all slots runs first.
// A finished result waits in the output register while the next item is taken.
`timescale 1ns / 1ps

module midi_track_note_extractor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic [7:0]         in_track_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic [39:0]        out_start_us,
  output logic [39:0]        out_duration_us,
  output logic [3:0]         out_channel_number,
  output logic [6:0]         out_note_number,
  output logic [21:0]        out_frequency_q8,
  output logic [3:0]         out_voice_class,
  output logic signed [15:0] out_pan_q14,
  output logic [39:0]        out_latest_end_us,
  output logic               out_track_aborted,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [14:0]        cfg_data
);
  import mtne_pkg::*;

  typedef enum logic [3:0] {
    PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_META_TYPE,
    PH_META_LEN, PH_TEMPO, PH_SYSEX_LEN, PH_SKIP
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_SLOT_RD, S_SLOT_MOD, S_SCAN, S_EMIT_A, S_EMIT_B, S_OUT
  } ctrl_t;

  localparam logic [SLOT_AW-1:0] LAST = SLOT_AW'(SLOT_COUNT - 1);

  ctrl_t              state_r;
  phase_t             phase_r;
  logic [14:0]        tpq_r;
  logic [7:0]         prog_r [16];
  logic [FX_W-1:0]    cur_time_r;
  logic [23:0]        tempo_r;
  logic [7:0]         rs_r;
  logic [31:0]        varlen_r;
  logic [31:0]        skip_r;
  logic [23:0]        held_r;
  logic [CURSOR_W-1:0] cursor_r;
  logic [FX_W-1:0]    latest_r;
  logic               aborted_r;
  logic               clr_start_r;

  logic [SLOT_AW-1:0] slot_idx_r;
  logic               msg_on_r;
  logic [SLOT_AW-1:0] scan_addr_r;
  logic [SLOT_AW-1:0] rd_addr_r;
  logic               rd_pend_r;

  logic [FX_W-1:0]    em_start_r;
  logic [FX_W-1:0]    em_dur_r;
  logic [3:0]         em_voice_r;
  logic [3:0]         em_ch_r;
  logic [KEY_W-1:0]   em_key_r;

  logic               res_kind_r;
  logic [FX_W-1:0]    res_start_r;
  logic [FX_W-1:0]    res_dur_r;
  logic [3:0]         res_ch_r;
  logic [KEY_W-1:0]   res_key_r;
  logic [3:0]         res_voice_r;
  logic [FX_W-1:0]    res_latest_r;
  logic               res_abort_r;

  logic               out_valid_r;
  logic               out_kind_r;
  logic [39:0]        out_start_r;
  logic [39:0]        out_dur_r;
  logic [3:0]         out_ch_r;
  logic [6:0]         out_key_r;
  logic [21:0]        out_freq_r;
  logic [3:0]         out_voice_r;
  logic signed [15:0] out_pan_r;
  logic [39:0]        out_latest_r;
  logic               out_abort_r;

  logic               in_accept;
  logic               clr_busy;
  logic [SLOT_AW-1:0] rd_addr;
  slot_t              rd_data;
  slot_wr_t           slot_wr;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic [31:0]        delta_acc;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE) || clr_busy;
  assign cfg_ready = 1'b1;
  assign delta_acc = {varlen_r[24:0], in_track_byte[6:0]};

  assign div_req.start   = in_accept && !in_command && !aborted_r &&
                           (phase_r == PH_DELTA) && !in_track_byte[7];
  assign div_req.ticks   = delta_acc;
  assign div_req.tempo   = tempo_r;
  assign div_req.divisor = (tpq_r == '0) ? 15'd1 : tpq_r;

  assign rd_addr = (state_r == S_SCAN) ? scan_addr_r : slot_idx_r;

  always_comb begin
    slot_wr = '0;
    if (state_r == S_SLOT_MOD) begin
      slot_wr.addr = slot_idx_r;
      if (msg_on_r) begin
        slot_wr.en            = 1'b1;
        slot_wr.data.active   = 1'b1;
        slot_wr.data.start_fx = cur_time_r;
        slot_wr.data.voice    = voice_of(prog_r[4'(slot_idx_r >> KEY_W)]);
      end else if (rd_data.active) begin
        slot_wr.en            = 1'b1;
        slot_wr.data.start_fx = rd_data.start_fx;
        slot_wr.data.voice    = rd_data.voice;
      end
    end else if (state_r == S_SCAN && rd_pend_r && rd_data.active) begin
      slot_wr.en            = 1'b1;
      slot_wr.addr          = rd_addr_r;
      slot_wr.data.start_fx = rd_data.start_fx;
      slot_wr.data.voice    = rd_data.voice;
    end
  end

  mtne_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  mtne_slot_store u_slots (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear_start (clr_start_r),
    .busy        (clr_busy),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr          (slot_wr)
  );

  always_ff @(posedge clk) begin : ctrl
    logic            do_track_rst;
    logic            do_done;
    logic            do_msg;
    logic [7:0]      m_st;
    logic [7:0]      m_d1;
    logic [7:0]      m_d2;
    logic [7:0]      b;
    logic [31:0]     vl;
    logic [31:0]     sk;
    logic [23:0]     hb;
    logic [FX_W-1:0] dur;
    logic [FX_W-1:0] fin;
    logic [FX_W-1:0] lat;
    do_track_rst = 1'b0;
    do_done      = 1'b0;
    do_msg       = 1'b0;
    m_st         = '0;
    m_d1         = '0;
    m_d2         = '0;
    b            = in_track_byte;
    vl           = {varlen_r[24:0], b[6:0]};
    sk           = skip_r - 32'd1;
    hb           = {held_r[15:0], b};
    dur          = (cur_time_r >= em_start_r) ? (cur_time_r - em_start_r) : '0;
    fin          = sat_add48(em_start_r, em_dur_r);
    lat          = (fin > latest_r) ? fin : latest_r;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_DELTA;
      tpq_r       <= TPQ_RESET;
      for (int i = 0; i < 16; i++) prog_r[i] <= '0;
      cur_time_r  <= '0;
      tempo_r     <= TEMPO_RESET;
      rs_r        <= '0;
      varlen_r    <= '0;
      skip_r      <= '0;
      held_r      <= '0;
      cursor_r    <= '0;
      latest_r    <= '0;
      aborted_r   <= 1'b0;
      clr_start_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_start_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        tpq_r <= cfg_data;
      end
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept && in_command) begin
            if (aborted_r) begin
              do_done     = 1'b1;
              clr_start_r <= 1'b1;
            end else begin
              scan_addr_r <= SLOT_AW'(cursor_r);
              rd_pend_r   <= 1'b0;
              state_r     <= S_SCAN;
            end
          end else if (in_accept) begin
            cursor_r <= '0;
            if (!aborted_r) begin
              unique case (phase_r)
                PH_DELTA: begin
                  if (b[7]) begin
                    varlen_r <= vl;
                  end else begin
                    varlen_r <= '0;
                    phase_r  <= PH_STATUS;
                    state_r  <= S_DIV;
                  end
                end
                PH_STATUS: begin
                  if (!b[7]) begin
                    if (rs_r == '0) begin
                      aborted_r <= 1'b1;
                    end else begin
                      m_st = rs_r;
                      m_d1 = b;
                      held_r <= {8'd0, b, rs_r};
                      if (rs_r[7:4] == TY_PROGRAM || rs_r[7:4] == TY_PRESSURE) begin
                        phase_r <= PH_DELTA;
                        do_msg = 1'b1;
                      end else begin
                        phase_r <= PH_DATA2;
                      end
                    end
                  end else if (b == ST_META) begin
                    rs_r    <= '0;
                    phase_r <= PH_META_TYPE;
                  end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
                    rs_r     <= '0;
                    varlen_r <= '0;
                    phase_r  <= PH_SYSEX_LEN;
                  end else begin
                    rs_r    <= b;
                    held_r  <= {16'd0, b};
                    phase_r <= PH_DATA1;
                  end
                end
                PH_DATA1: begin
                  m_st = held_r[7:0];
                  m_d1 = b;
                  held_r <= {8'd0, b, held_r[7:0]};
                  if (held_r[7:4] == TY_PROGRAM || held_r[7:4] == TY_PRESSURE) begin
                    phase_r <= PH_DELTA;
                    do_msg = 1'b1;
                  end else begin
                    phase_r <= PH_DATA2;
                  end
                end
                PH_DATA2: begin
                  phase_r <= PH_DELTA;
                  m_st   = held_r[7:0];
                  m_d1   = held_r[15:8];
                  m_d2   = b;
                  do_msg = 1'b1;
                end
                PH_META_TYPE: begin
                  held_r   <= {16'd0, b};
                  varlen_r <= '0;
                  phase_r  <= PH_META_LEN;
                end
                PH_META_LEN, PH_SYSEX_LEN: begin
                  if (b[7]) begin
                    varlen_r <= vl;
                  end else begin
                    varlen_r <= '0;
                    if (phase_r == PH_META_LEN && held_r[7:0] == META_TEMPO &&
                        vl == 32'd3) begin
                      held_r  <= '0;
                      skip_r  <= 32'd3;
                      phase_r <= PH_TEMPO;
                    end else begin
                      skip_r  <= vl;
                      phase_r <= (vl != '0) ? PH_SKIP : PH_DELTA;
                    end
                  end
                end
                PH_TEMPO: begin
                  held_r <= hb;
                  skip_r <= sk;
                  if (sk == '0) begin
                    tempo_r <= hb;
                    phase_r <= PH_DELTA;
                  end
                end
                PH_SKIP: begin
                  skip_r <= sk;
                  if (sk == '0) begin
                    phase_r <= PH_DELTA;
                  end
                end
                default: phase_r <= PH_DELTA;
              endcase
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            cur_time_r <= sat_add48(cur_time_r, div_rsp.delta_fx);
            state_r    <= S_IDLE;
          end
        end
        S_SLOT_RD: state_r <= S_SLOT_MOD;
        S_SLOT_MOD: begin
          em_start_r <= rd_data.start_fx;
          em_voice_r <= rd_data.voice;
          em_ch_r    <= 4'(slot_idx_r >> KEY_W);
          em_key_r   <= slot_idx_r[KEY_W-1:0];
          state_r    <= rd_data.active ? S_EMIT_A : S_IDLE;
        end
        S_SCAN: begin
          if (rd_pend_r && rd_data.active) begin
            em_start_r <= rd_data.start_fx;
            em_voice_r <= rd_data.voice;
            em_ch_r    <= 4'(rd_addr_r >> KEY_W);
            em_key_r   <= rd_addr_r[KEY_W-1:0];
            cursor_r   <= CURSOR_W'(rd_addr_r) + CURSOR_W'(1);
            state_r    <= S_EMIT_A;
          end else if (rd_pend_r && rd_addr_r == LAST) begin
            do_done = 1'b1;
          end else begin
            rd_addr_r <= scan_addr_r;
            rd_pend_r <= 1'b1;
            if (scan_addr_r != LAST) begin
              scan_addr_r <= scan_addr_r + 1'b1;
            end
          end
        end
        S_EMIT_A: begin
          em_dur_r <= (dur < MIN_DUR_FX) ? MIN_DUR_FX : dur;
          state_r  <= S_EMIT_B;
        end
        S_EMIT_B: begin
          latest_r     <= lat;
          res_kind_r   <= KIND_NOTE;
          res_start_r  <= em_start_r;
          res_dur_r    <= em_dur_r;
          res_ch_r     <= em_ch_r;
          res_key_r    <= em_key_r;
          res_voice_r  <= em_voice_r;
          res_latest_r <= lat;
          res_abort_r  <= 1'b0;
          state_r      <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= res_kind_r;
            out_start_r  <= fx_to_us(res_start_r);
            out_dur_r    <= fx_to_us(res_dur_r);
            out_ch_r     <= res_ch_r;
            out_key_r    <= res_key_r;
            out_freq_r   <= (res_kind_r == KIND_DONE) ? 22'd0 : FREQ_TAB[res_key_r];
            out_voice_r  <= res_voice_r;
            out_pan_r    <= (res_kind_r == KIND_DONE) ? 16'sd0 : PAN_TAB[res_ch_r];
            out_latest_r <= fx_to_us(res_latest_r);
            out_abort_r  <= res_abort_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (do_msg && ({1'b0, m_st[3:0]} < 5'(CHANNELS))) begin
        if (m_st[7:4] == TY_NOTE_ON || m_st[7:4] == TY_NOTE_OFF) begin
          slot_idx_r <= SLOT_AW'({m_st[3:0], m_d1[KEY_W-1:0]});
          msg_on_r   <= (m_st[7:4] == TY_NOTE_ON) && (m_d2 != 8'd0);
          state_r    <= S_SLOT_RD;
        end else if (m_st[7:4] == TY_PROGRAM) begin
          prog_r[m_st[3:0]] <= m_d1;
        end
      end

      if (do_done) begin
        res_kind_r   <= KIND_DONE;
        res_start_r  <= '0;
        res_dur_r    <= '0;
        res_ch_r     <= '0;
        res_key_r    <= '0;
        res_voice_r  <= '0;
        res_latest_r <= latest_r;
        res_abort_r  <= aborted_r;
        state_r      <= S_OUT;
        do_track_rst = 1'b1;
      end

      if (do_track_rst) begin
        for (int i = 0; i < 16; i++) prog_r[i] <= '0;
        cur_time_r <= '0;
        tempo_r    <= TEMPO_RESET;
        rs_r       <= '0;
        phase_r    <= PH_DELTA;
        varlen_r   <= '0;
        skip_r     <= '0;
        held_r     <= '0;
        cursor_r   <= '0;
        aborted_r  <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_start_us       = out_start_r;
  assign out_duration_us    = out_dur_r;
  assign out_channel_number = out_ch_r;
  assign out_note_number    = out_key_r;
  assign out_frequency_q8   = out_freq_r;
  assign out_voice_class    = out_voice_r;
  assign out_pan_q14        = out_pan_r;
  assign out_latest_end_us  = out_latest_r;
  assign out_track_aborted  = out_abort_r;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV)
    else $error("divider finished outside the delta wait");

  a_no_write_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    slot_wr.en |-> !clr_busy)
    else $error("slot write during the clearing pass");

  a_min_duration: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_NOTE) |-> out_duration_us >= 40'd10000)
    else $error("note item shorter than the minimum duration");

endmodule

// File: test/midi_track_note_extractor_tb.sv
// Self-checking testbench for midi_track_note_extractor: it drives track bytes and flush steps
// with random idling, predicts every finished note and flush result, and compares them.
// Depends on mtne_pkg and the RTL of the block.
`timescale 1ns / 1ps

module midi_track_note_extractor_tb;
  import mtne_pkg::*;

  typedef enum logic [3:0] {
    P_DELTA, P_STATUS, P_DATA1, P_DATA2, P_META_TYPE, P_META_LEN, P_TEMPO, P_SYSEX_LEN, P_SKIP
  } parse_ph_t;

  localparam logic [3:0] TY_AFTERTOUCH = 4'hA;
  localparam logic [3:0] TY_CONTROL    = 4'hB;
  localparam logic [3:0] TY_BEND       = 4'hE;
  localparam logic [7:0] ST_SONG_POS   = 8'hF2;
  localparam longint unsigned FX_MAX   = 64'hFFFF_FFFF_FFFF;
  localparam longint unsigned US_MAX   = 64'hFF_FFFF_FFFF;
  localparam longint unsigned DUR_MIN  = 64'd10000 << 8;

  typedef struct {
    bit                 kind;
    longint unsigned    start_us;
    longint unsigned    duration_us;
    bit [3:0]           channel;
    bit [6:0]           key;
    bit [21:0]          freq;
    bit [3:0]           voice;
    bit signed [15:0]   pan;
    longint unsigned    latest_us;
    bit                 aborted;
  } note_res_t;

  class note_scoreboard;
    bit [14:0]       tpq = TPQ_RESET;
    bit              active [SLOT_COUNT];
    longint unsigned start_fx [SLOT_COUNT];
    bit [3:0]        voice [SLOT_COUNT];
    bit [7:0]        prog_tab [16];
    longint unsigned now_fx, latest_fx;
    bit [23:0]       tempo;
    bit [7:0]        run_status;
    parse_ph_t       phase;
    bit [31:0]       acc, skip_left, held;
    int              cursor;
    bit              aborted, last_done;
    note_res_t       pending_q [$];
    int              errors, notes, flushes, aborts;
    longint unsigned nano [12] = '{
      64'd2093004522405, 64'd2217461047815, 64'd2349318143339, 64'd2489015869777,
      64'd2637020455303, 64'd2793825851464, 64'd2959955381693, 64'd3135963487854,
      64'd3322437580640, 64'd3520000000000, 64'd3729310092145, 64'd3951066410049};
    bit [3:0]        voice_map [36] = '{
      0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 2, 2, 2, 2, 3, 3, 3, 3,
      4, 4, 4, 4, 5, 5, 5, 6, 7, 7, 7, 8, 9, 8, 10, 10};

    function new();
      latest_fx = 0;
      clear_track();
    endfunction

    function void clear_track();
      foreach (active[i]) begin
        active[i] = 0;
        start_fx[i] = 0;
        voice[i] = 0;
      end
      foreach (prog_tab[i]) prog_tab[i] = 0;
      now_fx = 0;
      tempo = TEMPO_RESET;
      run_status = 0;
      phase = P_DELTA;
      acc = 0;
      skip_left = 0;
      held = 0;
      cursor = 0;
      aborted = 0;
    endfunction

    function longint unsigned sat_sum(longint unsigned a, longint unsigned b);
      return (a + b > FX_MAX) ? FX_MAX : a + b;
    endfunction

    function longint unsigned to_us(longint unsigned fx);
      return ((fx >> 8) > US_MAX) ? US_MAX : fx >> 8;
    endfunction

    function longint unsigned ticks_to_fx(bit [31:0] ticks);
      longint unsigned d, prod, q, r;
      d = (tpq == 0) ? 1 : tpq;
      prod = longint'(ticks) * longint'(tempo);
      q = prod / d;
      r = prod % d;
      if ((q >> 40) != 0) return FX_MAX;
      return (q << 8) + ((r << 8) / d);
    endfunction

    function void finish_note(int idx);
      note_res_t       n;
      longint unsigned dur, fin, v;
      int              ch, key, num;
      ch = idx / 128;
      key = idx % 128;
      dur = (now_fx >= start_fx[idx]) ? now_fx - start_fx[idx] : 0;
      if (dur < DUR_MIN) dur = DUR_MIN;
      fin = sat_sum(start_fx[idx], dur);
      if (fin > latest_fx) latest_fx = fin;
      v = nano[key % 12] << (key / 12);
      num = (ch * 2 - 15) * 16384;
      n.kind = KIND_NOTE;
      n.start_us = to_us(start_fx[idx]);
      n.duration_us = to_us(dur);
      n.channel = 4'(ch);
      n.key = 7'(key);
      n.freq = 22'((v + 64'd500000000) / 64'd1000000000);
      n.voice = voice[idx];
      n.pan = 16'((num >= 0) ? (num + 7) / 15 : -((-num + 7) / 15));
      n.latest_us = to_us(latest_fx);
      n.aborted = 0;
      pending_q.push_back(n);
    endfunction

    function void channel_event(bit [7:0] st, bit [7:0] d1, bit [7:0] d2);
      int idx;
      idx = st[3:0] * 128 + d1[6:0];
      if (st[7:4] == TY_NOTE_ON && d2 != 0) begin
        if (active[idx]) finish_note(idx);
        active[idx] = 1;
        start_fx[idx] = now_fx;
        voice[idx] = (prog_tab[st[3:0]] < 36) ? voice_map[prog_tab[st[3:0]]] : 4'd0;
      end else if (st[7:4] == TY_NOTE_ON || st[7:4] == TY_NOTE_OFF) begin
        if (active[idx]) begin
          finish_note(idx);
          active[idx] = 0;
        end
      end else if (st[7:4] == TY_PROGRAM) begin
        prog_tab[st[3:0]] = d1;
      end
    endfunction

    function void first_data(bit [7:0] d1);
      bit [7:0] st;
      st = held[7:0];
      held = {16'd0, d1, st};
      if (st[7:4] == TY_PROGRAM || st[7:4] == TY_PRESSURE) begin
        phase = P_DELTA;
        channel_event(st, d1, 8'd0);
      end else begin
        phase = P_DATA2;
      end
    endfunction

    function void parse_byte(bit [7:0] b);
      cursor = 0;
      if (aborted) return;
      case (phase)
        P_DELTA: begin
          acc = {acc[24:0], b[6:0]};
          if (!b[7]) begin
            now_fx = sat_sum(now_fx, ticks_to_fx(acc));
            acc = 0;
            phase = P_STATUS;
          end
        end
        P_STATUS: begin
          if (!b[7]) begin
            if (run_status == 0) begin
              aborted = 1;
            end else begin
              held = {24'd0, run_status};
              first_data(b);
            end
          end else if (b == ST_META) begin
            run_status = 0;
            phase = P_META_TYPE;
          end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
            run_status = 0;
            acc = 0;
            phase = P_SYSEX_LEN;
          end else begin
            run_status = b;
            held = {24'd0, b};
            phase = P_DATA1;
          end
        end
        P_DATA1: first_data(b);
        P_DATA2: begin
          phase = P_DELTA;
          channel_event(held[7:0], held[15:8], b);
        end
        P_META_TYPE: begin
          held = {24'd0, b};
          acc = 0;
          phase = P_META_LEN;
        end
        P_META_LEN, P_SYSEX_LEN: begin
          acc = {acc[24:0], b[6:0]};
          if (!b[7]) begin
            if (phase == P_META_LEN && held[7:0] == META_TEMPO && acc == 3) begin
              held = 0;
              skip_left = 3;
              phase = P_TEMPO;
            end else begin
              skip_left = acc;
              phase = (acc != 0) ? P_SKIP : P_DELTA;
            end
            acc = 0;
          end
        end
        P_TEMPO: begin
          held = {8'd0, held[15:0], b};
          skip_left--;
          if (skip_left == 0) begin
            tempo = held[23:0];
            phase = P_DELTA;
          end
        end
        P_SKIP: begin
          skip_left--;
          if (skip_left == 0) phase = P_DELTA;
        end
        default: phase = P_DELTA;
      endcase
    endfunction

    function void flush_once();
      note_res_t n;
      if (!aborted) begin
        for (int i = cursor; i < SLOT_COUNT; i++) begin
          if (active[i]) begin
            finish_note(i);
            active[i] = 0;
            cursor = (i + 1) % SLOT_COUNT;
            return;
          end
        end
      end
      n = '{default: 0};
      n.kind = KIND_DONE;
      n.latest_us = to_us(latest_fx);
      n.aborted = aborted;
      pending_q.push_back(n);
      flushes++;
      if (aborted) aborts++;
      last_done = 1;
      clear_track();
    endfunction

    function void take_item(bit cmd, bit [7:0] b);
      last_done = 0;
      if (cmd) flush_once();
      else parse_byte(b);
    endfunction

    function bit differs(string name, longint unsigned e, longint unsigned a);
      if (e != a) $display("%0t ns: %s expected %0d, got %0d", $time, name, e, a);
      return e != a;
    endfunction

    function void check_result(note_res_t got);
      note_res_t e;
      bit        bad;
      if (pending_q.size() == 0) begin
        $display("%0t ns: result with nothing expected, kind %0d key %0d", $time,
                 got.kind, got.key);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      bad = differs("kind", e.kind, got.kind);
      bad |= differs("start_us", e.start_us, got.start_us);
      bad |= differs("duration_us", e.duration_us, got.duration_us);
      bad |= differs("channel_number", e.channel, got.channel);
      bad |= differs("note_number", e.key, got.key);
      bad |= differs("frequency_q8", e.freq, got.freq);
      bad |= differs("voice_class", e.voice, got.voice);
      bad |= differs("pan_q14", e.pan[15:0], got.pan[15:0]);
      bad |= differs("latest_end_us", e.latest_us, got.latest_us);
      bad |= differs("track_aborted", e.aborted, got.aborted);
      if (bad) errors++;
      if (e.kind == KIND_NOTE) notes++;
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic               in_command = 0;
  logic [7:0]         in_track_byte = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic               out_kind;
  logic [39:0]        out_start_us, out_duration_us, out_latest_end_us;
  logic [3:0]         out_channel_number, out_voice_class;
  logic [6:0]         out_note_number;
  logic [21:0]        out_frequency_q8;
  logic signed [15:0] out_pan_q14;
  logic               out_track_aborted;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [14:0]        cfg_data = 0;

  note_scoreboard sb = new();
  bit             idle_on = 1;
  int             hold_left = 0;
  int             items_sent = 0;

  midi_track_note_extractor i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_track_byte(in_track_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_start_us(out_start_us), .out_duration_us(out_duration_us),
    .out_channel_number(out_channel_number), .out_note_number(out_note_number),
    .out_frequency_q8(out_frequency_q8), .out_voice_class(out_voice_class),
    .out_pan_q14(out_pan_q14), .out_latest_end_us(out_latest_end_us),
    .out_track_aborted(out_track_aborted),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #100ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // The receiver: checks at the rising edge, decides its stall at the falling edge.
  initial begin
    note_res_t r;
    int        burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        r.kind = out_kind;
        r.start_us = out_start_us;
        r.duration_us = out_duration_us;
        r.channel = out_channel_number;
        r.key = out_note_number;
        r.freq = out_frequency_q8;
        r.voice = out_voice_class;
        r.pan = out_pan_q14;
        r.latest_us = out_latest_end_us;
        r.aborted = out_track_aborted;
        sb.check_result(r);
      end
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1;
      end else if (burst > 0) begin
        burst--;
        out_stall = 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 12) - 1;
        out_stall = 1;
      end else begin
        out_stall = 0;
      end
    end
  end

  task automatic send(bit cmd, bit [7:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_valid = 0;
      in_command = 1'($urandom_range(0, 1));
      in_track_byte = 8'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1;
    in_command = cmd;
    in_track_byte = cmd ? 8'($urandom) : b;
    do @(posedge clk); while (in_stall);
    sb.take_item(cmd, b);
    items_sent++;
  endtask

  task automatic write_tpq(bit [14:0] v);
    @(negedge clk);
    in_valid = 0;
    cfg_valid = 1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    sb.tpq = v;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    wait (sb.pending_q.size() == 0);
    repeat (2200) @(posedge clk);
  endtask

  task automatic send_delta(bit [31:0] ticks, int extra);
    bit [7:0] q [$];
    q.push_front({1'b0, ticks[6:0]});
    ticks >>= 7;
    while (ticks != 0 || extra > 0) begin
      q.push_front({1'b1, ticks[6:0]});
      ticks >>= 7;
      if (ticks == 0 && extra > 0) extra--;
    end
    foreach (q[i]) send(0, q[i]);
  endtask

  task automatic flush_track();
    do begin
      send(1, 0);
      if (!sb.last_done && $urandom_range(0, 15) == 0) send(0, 8'($urandom));
    end while (!sb.last_done);
  endtask

  task automatic random_event();
    int       pick, len;
    bit [3:0] ch;
    bit [7:0] key;
    bit [7:0] tmeta;
    pick = $urandom_range(0, 99);
    ch = ($urandom_range(0, 3) == 0) ? 4'($urandom) : (($urandom_range(0, 1)) ? 4'd0 : 4'd15);
    key = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'(60 + $urandom_range(0, 5));
    if ($urandom_range(0, 9) == 0) send_delta($urandom, $urandom_range(0, 2));
    else send_delta($urandom_range(0, 300), 0);
    if (pick < 60) begin
      if (!(sb.run_status[7:4] inside {TY_NOTE_ON, TY_NOTE_OFF}) || $urandom_range(0, 2) != 0)
        send(0, {($urandom_range(0, 2) != 0) ? TY_NOTE_ON : TY_NOTE_OFF, ch});
      send(0, key);
      send(0, ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
    end else if (pick < 70) begin
      send(0, {TY_PROGRAM, ch});
      send(0, ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 37)));
    end else if (pick < 76) begin
      send(0, {TY_PRESSURE, ch});
      send(0, 8'($urandom));
    end else if (pick < 82) begin
      case ($urandom_range(0, 3))
        0: send(0, {TY_AFTERTOUCH, ch});
        1: send(0, {TY_CONTROL, ch});
        2: send(0, {TY_BEND, ch});
        default: send(0, 8'($urandom_range(8'hF1, 8'hFE)) == ST_SYSEX_ESC ? ST_SONG_POS
                                                                          : 8'hF1);
      endcase
      send(0, 8'($urandom));
      send(0, 8'($urandom));
    end else if (pick < 88) begin
      send(0, ST_META);
      send(0, META_TEMPO);
      send(0, 8'd3);
      case ($urandom_range(0, 3))
        0: begin send(0, 0); send(0, 0); send(0, 8'($urandom_range(1, 255))); end
        1: begin send(0, 8'hFF); send(0, 8'hFF); send(0, 8'hFF); end
        default: begin send(0, 8'h07); send(0, 8'($urandom)); send(0, 8'($urandom)); end
      endcase
    end else if (pick < 94) begin
      tmeta = ($urandom_range(0, 3) == 0) ? META_TEMPO : 8'($urandom);
      len = $urandom_range(0, 5);
      if (tmeta == META_TEMPO && len == 3) len = 4;
      send(0, ST_META);
      send(0, tmeta);
      if ($urandom_range(0, 5) == 0) send(0, 8'h80);
      send(0, 8'(len));
      repeat (len) send(0, 8'($urandom));
    end else if (pick < 97) begin
      len = $urandom_range(0, 6);
      send(0, ($urandom_range(0, 1)) ? ST_SYSEX : ST_SYSEX_ESC);
      send(0, 8'(len));
      repeat (len) send(0, 8'($urandom));
    end else if (pick < 98 && sb.run_status == 0) begin
      send(0, 8'($urandom_range(0, 127)));
    end else begin
      send(0, 8'($urandom));
    end
  endtask

  task automatic random_phase(int n);
    int stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if (items_sent > 900) idle_on = 0;
      random_event();
      if ($urandom_range(0, 40) == 0) flush_track();
    end
    flush_track();
  endtask

  initial begin
    bit [14:0] tpq_set [5];
    tpq_set = '{15'd1, 15'd32767, 15'd0, 15'($urandom_range(2, 32766)), TPQ_RESET};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    write_tpq(15'd100);

    // Track abandoned on a data byte without status, then a normal track.
    send(0, 8'h00); send(0, 8'h40); send(0, {TY_NOTE_ON, 4'h0});
    flush_track();
    send_delta(32'd128, 0);
    send(0, {TY_NOTE_ON, 4'hF}); send(0, 8'h7F); send(0, 8'h7F);
    send_delta(32'h0FFF_FFFF, 0);
    send(0, 8'h7F); send(0, 8'h00);
    send_delta(32'd0, 0);
    send(0, {TY_NOTE_ON, 4'h0}); send(0, 8'h80); send(0, 8'h01);
    send_delta(32'd0, 0);
    send(0, ST_META); send(0, META_TEMPO); send(0, 8'd3);
    send(0, 8'hFF); send(0, 8'hFF); send(0, 8'hFF);
    send_delta(32'd5, 0);
    send(0, {TY_PROGRAM, 4'h0}); send(0, 8'hFF);
    flush_track();

    foreach (tpq_set[i]) begin
      drain();
      write_tpq(tpq_set[i]);
      if (i == 1) hold_left = 400;
      random_phase(200);
    end

    drain();
    $display("Sent %0d items over six tick divisions, %0d notes checked,", items_sent,
             sb.notes);
    $display("%0d track flushes of which %0d on abandoned tracks.", sb.flushes, sb.aborts);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/mtne_pkg.sv
rtl/mtne_divider.sv
rtl/mtne_slot_store.sv
rtl/midi_track_note_extractor.sv
test/midi_track_note_extractor_tb.sv
